>>> hw/rtl/fcsg_pkg.sv
// Shared types, constants and the microcode program of the circle span generator.
package fcsg_pkg;

  localparam int CW = 14;           // centre coordinate width
  localparam int SW = 15;           // span coordinate width
  localparam int RW = 5;            // radius / half-width width
  localparam int NW = 2 * RW;       // width of r*r - k*k
  localparam int REMW = RW + 1;     // sqrt partial remainder width
  localparam int SQ_ITER = NW / 2;  // one root bit per iteration
  localparam int PCW = 3;

  localparam logic [PCW-1:0] STEP_IDLE = 3'd0;
  localparam logic [PCW-1:0] STEP_CHK  = 3'd1;
  localparam logic [PCW-1:0] STEP_INIT = 3'd2;
  localparam logic [PCW-1:0] STEP_SQ   = 3'd3;
  localparam logic [PCW-1:0] STEP_RND  = 3'd4;
  localparam logic [PCW-1:0] STEP_UP   = 3'd5;
  localparam logic [PCW-1:0] STEP_LO   = 3'd6;
  localparam logic [PCW-1:0] STEP_MID  = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQINIT,
    OP_SQSTEP,
    OP_ROUND,
    OP_EMIT_UP,
    OP_EMIT_LO,
    OP_EMIT_MID
  } fcsg_op_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_JMP,
    C_KZERO,
    C_CNT
  } fcsg_cond_t;

  typedef struct packed {
    fcsg_op_t         op;
    fcsg_cond_t       cond;
    logic [PCW-1:0]   target;
  } fcsg_cw_t;

  typedef struct packed {
    logic init;
    logic step;
  } fcsg_sq_ctl_t;

  function automatic fcsg_cw_t ucode(input logic [PCW-1:0] pc);
    fcsg_cw_t cw;
    unique case (pc)
      STEP_IDLE: cw = '{op: OP_LOAD,     cond: C_NEXT,  target: STEP_IDLE};
      STEP_CHK:  cw = '{op: OP_NOP,      cond: C_KZERO, target: STEP_MID};
      STEP_INIT: cw = '{op: OP_SQINIT,   cond: C_NEXT,  target: STEP_IDLE};
      STEP_SQ:   cw = '{op: OP_SQSTEP,   cond: C_CNT,   target: STEP_IDLE};
      STEP_RND:  cw = '{op: OP_ROUND,    cond: C_NEXT,  target: STEP_IDLE};
      STEP_UP:   cw = '{op: OP_EMIT_UP,  cond: C_NEXT,  target: STEP_IDLE};
      STEP_LO:   cw = '{op: OP_EMIT_LO,  cond: C_JMP,   target: STEP_CHK};
      STEP_MID:  cw = '{op: OP_EMIT_MID, cond: C_JMP,   target: STEP_IDLE};
      default:   cw = '{op: OP_NOP,      cond: C_JMP,   target: STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> hw/rtl/filled_circle_span_generator_core.sv
// Filled circle span generator: top level with microcode sequencer and span datapath.
// One request (centre, radius) yields 2r+1 spans: for each row offset k from r down to 1
// the upper row then the lower row, with half-width round(sqrt(r*r - k*k)), and last a
// middle row span flagged last_span. Radius is saturated to MAX_RADIUS. A request is
// sequenced by the eight-step microcode program, whose square root step repeats once per
// root bit, one root bit per cycle. The next request is taken while the final span still
// waits at the output.
module filled_circle_span_generator_core #(
  parameter int MAX_RADIUS = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [31:0]                    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [fcsg_pkg::CW-1:0] in_center_x,
  input  logic signed [fcsg_pkg::CW-1:0] in_center_y,
  input  logic [fcsg_pkg::RW-1:0]        in_radius,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [fcsg_pkg::SW-1:0] out_span_x,
  output logic signed [fcsg_pkg::SW-1:0] out_span_y,
  output logic [fcsg_pkg::RW:0]          out_span_width,
  output logic [31:0]                    out_span_colour,
  output logic                           out_last_span
);

  localparam logic [fcsg_pkg::RW-1:0] RMAX = fcsg_pkg::RW'(MAX_RADIUS);

  logic [fcsg_pkg::PCW-1:0]      pc_r, pc_nxt;
  fcsg_pkg::fcsg_cw_t            cw;
  logic                          go;
  logic                          in_fire;
  logic                          ofree;

  logic [31:0]                   colour_r;
  logic signed [fcsg_pkg::SW-1:0] x_r, y_r;
  logic [fcsg_pkg::RW-1:0]       r_r, k_r, h_r;
  logic [fcsg_pkg::NW-1:0]       r2_r;
  logic [2:0]                    cnt_r;
  logic [fcsg_pkg::RW-1:0]       r_sat;
  logic [fcsg_pkg::NW-1:0]       n_w;

  logic                          out_valid_r;
  logic signed [fcsg_pkg::SW-1:0] span_x_r, span_y_r;
  logic [fcsg_pkg::RW:0]         span_w_r;
  logic [31:0]                   span_c_r;
  logic                          last_r;

  fcsg_pkg::fcsg_sq_ctl_t        sq_ctl;
  logic [fcsg_pkg::RW-1:0]       sq_root;
  logic [fcsg_pkg::REMW-1:0]     sq_rem;

  assign cw       = fcsg_pkg::ucode(pc_r);
  assign in_stall = (cw.op != fcsg_pkg::OP_LOAD);
  assign in_fire  = in_valid && !in_stall;
  assign ofree    = !out_valid_r || !out_stall;
  assign r_sat    = (in_radius > RMAX) ? RMAX : in_radius;
  assign n_w      = r2_r - fcsg_pkg::NW'(k_r) * fcsg_pkg::NW'(k_r);

  always_comb begin
    unique case (cw.op)
      fcsg_pkg::OP_LOAD:     go = in_fire;
      fcsg_pkg::OP_EMIT_UP,
      fcsg_pkg::OP_EMIT_LO,
      fcsg_pkg::OP_EMIT_MID: go = ofree;
      default:               go = 1'b1;
    endcase
  end

  // sequencer: step counter with conditional jumps
  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      unique case (cw.cond)
        fcsg_pkg::C_NEXT:  pc_nxt = pc_r + 3'd1;
        fcsg_pkg::C_JMP:   pc_nxt = cw.target;
        fcsg_pkg::C_KZERO: pc_nxt = (k_r == '0) ? cw.target : pc_r + 3'd1;
        fcsg_pkg::C_CNT:   pc_nxt = (cnt_r != '0) ? pc_r : pc_r + 3'd1;
        default:           pc_nxt = fcsg_pkg::STEP_IDLE;
      endcase
    end
  end

  always_comb begin
    sq_ctl.init = (cw.op == fcsg_pkg::OP_SQINIT);
    sq_ctl.step = (cw.op == fcsg_pkg::OP_SQSTEP);
  end

  fcsg_sqrt u_sqrt (
    .clk  (clk),
    .ctl  (sq_ctl),
    .n    (n_w),
    .root (sq_root),
    .rem  (sq_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= fcsg_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
      colour_r    <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr_en) colour_r <= cfg_wr_data;
      if (go && (cw.op == fcsg_pkg::OP_EMIT_UP || cw.op == fcsg_pkg::OP_EMIT_LO ||
                 cw.op == fcsg_pkg::OP_EMIT_MID))
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      unique case (cw.op)
        fcsg_pkg::OP_LOAD: begin
          x_r  <= fcsg_pkg::SW'(in_center_x);
          y_r  <= fcsg_pkg::SW'(in_center_y);
          r_r  <= r_sat;
          k_r  <= r_sat;
          r2_r <= fcsg_pkg::NW'(r_sat) * fcsg_pkg::NW'(r_sat);
        end
        fcsg_pkg::OP_SQINIT: cnt_r <= 3'(fcsg_pkg::SQ_ITER - 1);
        fcsg_pkg::OP_SQSTEP: if (cnt_r != '0) cnt_r <= cnt_r - 3'd1;
        // round to nearest: bump when n > s*s + s
        fcsg_pkg::OP_ROUND: h_r <= sq_root + fcsg_pkg::RW'(sq_rem > {1'b0, sq_root});
        fcsg_pkg::OP_EMIT_UP: begin
          span_x_r <= x_r - fcsg_pkg::SW'(h_r);
          span_y_r <= y_r - fcsg_pkg::SW'(k_r);
          span_w_r <= {h_r, 1'b0};
          span_c_r <= colour_r;
          last_r   <= 1'b0;
        end
        fcsg_pkg::OP_EMIT_LO: begin
          span_x_r <= x_r - fcsg_pkg::SW'(h_r);
          span_y_r <= y_r + fcsg_pkg::SW'(k_r);
          span_w_r <= {h_r, 1'b0};
          span_c_r <= colour_r;
          last_r   <= 1'b0;
          k_r      <= k_r - 5'd1;
        end
        fcsg_pkg::OP_EMIT_MID: begin
          span_x_r <= x_r - fcsg_pkg::SW'(r_r);
          span_y_r <= y_r;
          span_w_r <= {r_r, 1'b0};
          span_c_r <= colour_r;
          last_r   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_span_x      = span_x_r;
  assign out_span_y      = span_y_r;
  assign out_span_width  = span_w_r;
  assign out_span_colour = span_c_r;
  assign out_last_span   = last_r;

  a_load_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> pc_r == fcsg_pkg::STEP_CHK)
    else $error("request accepted but sequencer did not move to row check");

  a_mid_last: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == fcsg_pkg::STEP_MID && ofree |=> out_valid && out_last_span)
    else $error("middle span not presented as last");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == fcsg_pkg::STEP_SQ |-> cnt_r <= 3'(fcsg_pkg::SQ_ITER - 1))
    else $error("sqrt iteration count out of range");

  a_h_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == fcsg_pkg::STEP_UP |-> h_r <= r_r && k_r != '0)
    else $error("half-width exceeds radius or row offset is zero");

endmodule

>>> hw/rtl/fcsg_sqrt.sv
// Digit-by-digit integer square root, one root bit per step.
module fcsg_sqrt (
  input  logic                          clk,
  input  fcsg_pkg::fcsg_sq_ctl_t        ctl,
  input  logic [fcsg_pkg::NW-1:0]       n,
  output logic [fcsg_pkg::RW-1:0]       root,
  output logic [fcsg_pkg::REMW-1:0]     rem
);

  logic [fcsg_pkg::NW-1:0]     sh_r;
  logic [fcsg_pkg::RW-1:0]     root_r;
  logic [fcsg_pkg::REMW-1:0]   rem_r;
  logic [fcsg_pkg::REMW+1:0]   rem_sh;
  logic [fcsg_pkg::REMW+1:0]   trial;
  logic                        take;

  always_comb begin
    rem_sh = {rem_r, sh_r[fcsg_pkg::NW-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      sh_r   <= n;
      root_r <= '0;
      rem_r  <= '0;
    end else if (ctl.step) begin
      sh_r   <= {sh_r[fcsg_pkg::NW-3:0], 2'b00};
      root_r <= {root_r[fcsg_pkg::RW-2:0], take};
      // remainder stays below 2*root+1, so it fits the narrow register
      rem_r  <= take ? fcsg_pkg::REMW'(rem_sh - trial) : fcsg_pkg::REMW'(rem_sh);
    end
  end

  assign root = root_r;
  assign rem  = rem_r;

endmodule
